[hdl/m3i_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and constants for the 3x3 Q16.16 matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int DIM      = 3;
  localparam int NELEM    = DIM * DIM;
  localparam int ELEM_W   = 32;
  localparam int PROD_W   = 2 * ELEM_W;        // element product
  localparam int COF_W    = PROD_W + 1;        // cofactor
  localparam int DET_W    = 98;                // determinant, Q48.48
  localparam int QUO_W    = ELEM_W + 1;        // quotient bits kept
  localparam int NUM_W    = COF_W + ELEM_W;    // cofactor scaled by 2^32
  localparam int REM_W    = DET_W + QUO_W;     // partial remainder
  localparam int FRONT_LAT = 7;
  localparam int LANE_LAT  = QUO_W + 2;

  localparam logic [ELEM_W-1:0] SAT_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic                     singular;
    logic                     overflow;
  } out_t;

  // front end result: cofactor magnitudes and determinant, sign apart
  typedef struct packed {
    logic [NELEM-1:0][COF_W-1:0] nmag;
    logic [NELEM-1:0]            nneg;
    logic [DET_W-1:0]            dmag;
    logic                        dneg;
    logic                        dzero;
  } front_t;

  typedef struct packed {
    logic [ELEM_W-1:0] val;
    logic              ovf;
  } lane_t;

endpackage

[hdl/m3i_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Cofactors and determinant, seven register stages, all exact.
// ----------------------------------------------------------------------------
module m3i_front (
  input  logic            clk_i,
  input  logic            en_i,
  input  m3i_pkg::in_t    data_i,
  output m3i_pkg::front_t res_o
);
  import m3i_pkg::*;

  // operand indices: cofactor k = m[IA]*m[IB] - m[IC]*m[ID]
  localparam int IA [NELEM] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int IB [NELEM] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int IC [NELEM] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int ID [NELEM] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  logic signed [ELEM_W-1:0] mm [NELEM];
  assign mm[0] = data_i.m00;
  assign mm[1] = data_i.m01;
  assign mm[2] = data_i.m02;
  assign mm[3] = data_i.m10;
  assign mm[4] = data_i.m11;
  assign mm[5] = data_i.m12;
  assign mm[6] = data_i.m20;
  assign mm[7] = data_i.m21;
  assign mm[8] = data_i.m22;

  logic signed [PROD_W-1:0] pa_q [NELEM];
  logic signed [PROD_W-1:0] pb_q [NELEM];
  logic signed [ELEM_W-1:0] r0_q [2:3][DIM];
  logic signed [COF_W-1:0]  cof_q [2:6][NELEM];
  logic signed [COF_W-1:0]  plo_q [DIM];
  logic signed [COF_W-1:0]  phi_q [DIM];
  logic signed [DET_W-1:0]  term_q [DIM];
  logic signed [DET_W-1:0]  s01_q, t2_q, det_q;
  front_t                   res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NELEM; k++) begin
        pa_q[k] <= PROD_W'(mm[IA[k]]) * PROD_W'(mm[IB[k]]);
        pb_q[k] <= PROD_W'(mm[IC[k]]) * PROD_W'(mm[ID[k]]);
        cof_q[2][k] <= {pa_q[k][PROD_W-1], pa_q[k]} - {pb_q[k][PROD_W-1], pb_q[k]};
        for (int s = 3; s <= 6; s++) cof_q[s][k] <= cof_q[s-1][k];
      end
      for (int j = 0; j < DIM; j++) begin
        r0_q[2][j] <= mm[j];
        r0_q[3][j] <= r0_q[2][j];
        // split the cofactor: signed upper part, unsigned lower word
        plo_q[j] <= COF_W'(r0_q[3][j]) *
                    $signed({1'b0, cof_q[2][j][ELEM_W-1:0]});
        phi_q[j] <= COF_W'(r0_q[3][j]) *
                    COF_W'($signed(cof_q[2][j][COF_W-1:ELEM_W]));
        term_q[j] <= $signed({phi_q[j][COF_W-1], phi_q[j], {ELEM_W{1'b0}}}) +
                     $signed({{(DET_W-COF_W){plo_q[j][COF_W-1]}}, plo_q[j]});
      end
      s01_q <= term_q[0] + term_q[1];
      t2_q  <= term_q[2];
      det_q <= s01_q + t2_q;
      res_q.dneg  <= det_q[DET_W-1];
      res_q.dmag  <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
      res_q.dzero <= (det_q == '0);
      for (int k = 0; k < NELEM; k++) begin
        res_q.nneg[k] <= cof_q[6][k][COF_W-1];
        res_q.nmag[k] <= cof_q[6][k][COF_W-1] ? COF_W'(-cof_q[6][k])
                                              : COF_W'(cof_q[6][k]);
      end
    end
  end

  assign res_o = res_q;

endmodule

[hdl/m3i_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_lane
// One inverse element: pipelined restoring divide, one quotient bit a stage,
// then sign and saturation.
// ----------------------------------------------------------------------------
module m3i_lane (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [m3i_pkg::COF_W-1:0]    nmag_i,
  input  logic                         nneg_i,
  input  logic [m3i_pkg::DET_W-1:0]    dmag_i,
  input  logic                         dneg_i,
  output m3i_pkg::lane_t               res_o
);
  import m3i_pkg::*;

  logic [REM_W-1:0] rem_q  [QUO_W+1];
  logic [DET_W-1:0] dm_q   [QUO_W+1];
  logic [QUO_W-1:0] quo_q  [QUO_W+1];
  logic             big_q  [QUO_W+1];
  logic             rneg_q [QUO_W+1];
  lane_t            res_q;

  logic [REM_W-1:0] num;
  assign num = {{(REM_W-NUM_W){1'b0}}, nmag_i, {ELEM_W{1'b0}}};

  // quotient at or above 2^33 saturates whatever the sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num;
      dm_q[0]   <= dmag_i;
      quo_q[0]  <= '0;
      big_q[0]  <= num >= {dmag_i, {QUO_W{1'b0}}};
      rneg_q[0] <= nneg_i ^ dneg_i;
    end
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - s;
    logic [REM_W-1:0] dsh;
    logic             ge;
    assign dsh = {{QUO_W{1'b0}}, dm_q[s-1]} << K;
    assign ge  = rem_q[s-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? rem_q[s-1] - dsh : rem_q[s-1];
        quo_q[s]  <= quo_q[s-1] | (ge ? (QUO_W'(1) << K) : '0);
        dm_q[s]   <= dm_q[s-1];
        big_q[s]  <= big_q[s-1];
        rneg_q[s] <= rneg_q[s-1];
      end
    end
  end

  logic [QUO_W-1:0] q;
  logic             sat_neg, sat_pos;
  assign q       = quo_q[QUO_W];
  assign sat_neg = big_q[QUO_W] || q[QUO_W-1] || (q[ELEM_W-1] && |q[ELEM_W-2:0]);
  assign sat_pos = big_q[QUO_W] || q[QUO_W-1] || q[ELEM_W-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (rneg_q[QUO_W]) begin
        res_q.val <= sat_neg ? SAT_NEG : ELEM_W'(-q[ELEM_W-1:0]);
        res_q.ovf <= sat_neg;
      end else begin
        res_q.val <= sat_pos ? SAT_POS : q[ELEM_W-1:0];
        res_q.ovf <= sat_pos;
      end
    end
  end

  assign res_o = res_q;

endmodule

[hdl/matrix3_inverse.sv]
`timescale 1ns / 1ps
// path: an accepted input beat passes the front end, the divide lanes and the output register
// throughput: one matrix per cycle unless the output stalls; nine divide lanes of 33 stages run side by side
// the whole pipeline advances together and holds while the output beat is stalled
// reset clears only the valid bits; the datapath registers carry no reset
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a 3x3 signed Q16.16 matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
module matrix3_inverse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  m3i_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output m3i_pkg::out_t  out_data_o
);
  import m3i_pkg::*;

  localparam int PIPE = FRONT_LAT + LANE_LAT;

  logic            en;
  logic [PIPE-1:0] vld_q;
  logic            out_valid_q;
  out_t            out_q, out_d;
  front_t          fr;
  lane_t           lane [NELEM];
  logic            sing_q [LANE_LAT];

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  m3i_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (in_data_i),
    .res_o  (fr)
  );

  // lane i*3+j takes cofactor j*3+i (adjugate is the transpose)
  for (genvar i = 0; i < DIM; i++) begin : g_row
    for (genvar j = 0; j < DIM; j++) begin : g_col
      m3i_lane u_lane (
        .clk_i  (clk_i),
        .en_i   (en),
        .nmag_i (fr.nmag[j*DIM+i]),
        .nneg_i (fr.nneg[j*DIM+i]),
        .dmag_i (fr.dmag),
        .dneg_i (fr.dneg),
        .res_o  (lane[i*DIM+j])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[0] <= fr.dzero;
      for (int s = 1; s < LANE_LAT; s++) sing_q[s] <= sing_q[s-1];
    end
  end

  // merge the lanes
  always_comb begin
    logic sing, ovf;
    sing = sing_q[LANE_LAT-1];
    ovf  = 1'b0;
    for (int k = 0; k < NELEM; k++) ovf = ovf | lane[k].ovf;
    out_d.r00      = sing ? '0 : $signed(lane[0].val);
    out_d.r01      = sing ? '0 : $signed(lane[1].val);
    out_d.r02      = sing ? '0 : $signed(lane[2].val);
    out_d.r10      = sing ? '0 : $signed(lane[3].val);
    out_d.r11      = sing ? '0 : $signed(lane[4].val);
    out_d.r12      = sing ? '0 : $signed(lane[5].val);
    out_d.r20      = sing ? '0 : $signed(lane[6].val);
    out_d.r21      = sing ? '0 : $signed(lane[7].val);
    out_d.r22      = sing ? '0 : $signed(lane[8].val);
    out_d.singular = sing;
    out_d.overflow = !sing && ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PIPE-2:0], in_valid_i};
      out_valid_q <= vld_q[PIPE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic sat_any;
  assign sat_any = (out_q.r00 == SAT_POS) || (out_q.r00 == SAT_NEG) ||
                   (out_q.r01 == SAT_POS) || (out_q.r01 == SAT_NEG) ||
                   (out_q.r02 == SAT_POS) || (out_q.r02 == SAT_NEG) ||
                   (out_q.r10 == SAT_POS) || (out_q.r10 == SAT_NEG) ||
                   (out_q.r11 == SAT_POS) || (out_q.r11 == SAT_NEG) ||
                   (out_q.r12 == SAT_POS) || (out_q.r12 == SAT_NEG) ||
                   (out_q.r20 == SAT_POS) || (out_q.r20 == SAT_NEG) ||
                   (out_q.r21 == SAT_POS) || (out_q.r21 == SAT_NEG) ||
                   (out_q.r22 == SAT_POS) || (out_q.r22 == SAT_NEG);

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output beat");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_q.singular) |->
      (!out_q.overflow && out_q.r00 == 0 && out_q.r11 == 0 && out_q.r22 == 0 &&
       out_q.r01 == 0 && out_q.r12 == 0 && out_q.r20 == 0))
    else $error("singular beat carries nonzero data");

  a_overflow_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_q.overflow) |-> sat_any)
    else $error("overflow flagged without a saturated element");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[PIPE-1]))
    else $error("output beat without a matching pipeline entry");

endmodule
